FILE: rtl/core/gbte_pkg.sv
// Shared types, constants and codes of the gap buffer text editor.
package gbte_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 13;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 2;

  localparam int unsigned IN_BITS      = 2 * POS_W + CHAR_W;
  localparam int unsigned IN_TDATA_W   = (IN_BITS + 7) / 8 * 8;
  localparam int unsigned OUT_BITS     = CHAR_W + LEN_W + HASH_W;
  localparam int unsigned OUT_TDATA_W  = (OUT_BITS + 7) / 8 * 8;

  typedef enum logic [OP_W-1:0] {
    OP_REPLACE = 2'd0,
    OP_CUT     = 2'd1,
    OP_READ    = 2'd2,
    OP_HASH    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  from_pos;
    logic [POS_W-1:0]  to_pos;
    logic [CHAR_W-1:0] char_value;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  text_length;
    logic [HASH_W-1:0] hash_value;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/gap_buffer_text_editor.sv
// Top level of the gap buffer text editor: stream ports, result register, text RAM.
//
// The text lives in a CAPACITY-byte RAM with one movable gap; one transaction on the
// slave stream runs one operation and yields one transaction on the master stream.
// Operations go one at a time through a sequencer that owns the single read and single
// write port of the text RAM. A rejected edit or a read of an empty text goes straight to
// its result; a read issues one RAM read and registers the byte it returns; a replace or
// cut first moves the |from_pos - gap start| bytes between gap and from_pos, one byte
// per cycle through the RAM (a cut whose range already holds the gap moves nothing), then
// commits the new length and, for a replace, writes the new character; a hash folds the
// text in, one byte folded per cycle. The next operation is taken as soon as the result
// has moved into the output register, even while that register still waits for the
// master side. The text RAM has no reset and needs no clearing pass: only bytes that
// were written are ever read back. Status in tuser is 0 ok, 1 range error, 2 buffer full.
module gap_buffer_text_editor
  import gbte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // from_pos [12:0], to_pos [25:13], char_value [33:26], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [OP_W-1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // char_out [7:0], text_length [20:8], hash_value [84:21], zero pad above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [STAT_W-1:0]      m_axis_tuser
);

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] mem_rdata;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  // Unpack the slave payload into an operation request.
  assign req.op         = op_e'(s_axis_tuser);
  assign req.from_pos   = s_axis_tdata[POS_W-1:0];
  assign req.to_pos     = s_axis_tdata[2*POS_W-1:POS_W];
  assign req.char_value = s_axis_tdata[2*POS_W+CHAR_W-1:2*POS_W];

  gbte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  gbte_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CHAR_W)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when empty or draining this cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until the master side takes the transaction.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                          out_q.hash_value, out_q.text_length, out_q.char_out};

endmodule

FILE: rtl/core/gbte_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module gbte_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/gbte_seq.sv
// Operation sequencer: range checks, gap moves, reads and hash walks over the text RAM.
module gbte_seq
  import gbte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output mem_req_t          mem_o,
  input  logic [CHAR_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE,
    S_COMMIT,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_HASH,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  gap_q, gap_d;
  logic [LEN_W-1:0]  len_q, len_d;
  status_e           status_q, status_d;
  logic              pend_q, pend_d;
  logic              up_q, up_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;

  req_t              req_q, req_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [LEN_W-1:0]  newlen_q, newlen_d;

  logic [LEN_W-1:0]  gsize;
  logic [ADDR_W-1:0] gsize_a;
  logic              range_ok;
  logic [LEN_W-1:0]  span;
  logic [LEN_W:0]    grown_len;
  logic              gap_in_range;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  rd_idx;
  logic              hash_issue;

  assign gsize        = LEN_W'(CAPACITY) - len_q;
  assign gsize_a      = gsize[ADDR_W-1:0];
  assign range_ok     = (req_q.from_pos <= req_q.to_pos) && (req_q.to_pos <= len_q);
  assign span         = req_q.to_pos - req_q.from_pos;
  assign grown_len    = {1'b0, len_q} - {1'b0, span} + (LEN_W+1)'(1);
  assign gap_in_range = (req_q.from_pos <= gap_q) && (gap_q <= req_q.to_pos);
  assign len_m1       = len_q - LEN_W'(1);
  assign rd_idx       = (req_q.from_pos > len_m1) ? len_m1 : req_q.from_pos;
  assign hash_issue   = (cnt_q != len_q);

  always_comb begin
    state_d   = state_q;
    gap_d     = gap_q;
    len_d     = len_q;
    status_d  = status_q;
    pend_d    = 1'b0;
    up_d      = up_q;
    cnt_d     = cnt_q;
    req_d     = req_q;
    char_d    = char_q;
    hash_d    = hash_q;
    ptr_d     = ptr_q;
    wr_addr_d = wr_addr_q;
    newlen_d  = newlen_q;
    mem_o     = '0;

    req_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);

    // Finish the write of a byte read in the previous cycle of a gap move.
    if (pend_q && state_q == S_MOVE) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = wr_addr_q;
      mem_o.wdata = mem_rdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_d = STAT_OK;
        char_d   = '0;
        hash_d   = '0;
        unique case (req_q.op)
          OP_REPLACE, OP_CUT: begin
            if (!range_ok) begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end else if (req_q.op == OP_REPLACE && grown_len > (LEN_W+1)'(CAPACITY)) begin
              status_d = STAT_FULL;
              state_d  = S_DONE;
            end else begin
              newlen_d = (req_q.op == OP_REPLACE) ? grown_len[LEN_W-1:0] : len_q - span;
              if (req_q.from_pos < gap_q) begin
                up_d  = 1'b0;
                cnt_d = gap_q - req_q.from_pos;
                ptr_d = gap_q[ADDR_W-1:0] - ADDR_W'(1);
              end else begin
                up_d  = 1'b1;
                cnt_d = req_q.from_pos - gap_q;
                ptr_d = gap_q[ADDR_W-1:0] + gsize_a;
              end
              // Gap already inside the cut range: just widen it.
              if (req_q.op == OP_CUT && gap_in_range) begin
                cnt_d = '0;
              end
              state_d = S_MOVE;
            end
          end
          OP_READ: begin
            if (len_q == '0) begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end else begin
              ptr_d   = (rd_idx < gap_q) ? rd_idx[ADDR_W-1:0]
                                         : rd_idx[ADDR_W-1:0] + gsize_a;
              state_d = S_RD_ISSUE;
            end
          end
          OP_HASH: begin
            cnt_d   = '0;
            state_d = S_HASH;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_MOVE: begin
        if (cnt_q != '0) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          pend_d      = 1'b1;
          cnt_d       = cnt_q - LEN_W'(1);
          ptr_d       = up_q ? ptr_q + ADDR_W'(1) : ptr_q - ADDR_W'(1);
          wr_addr_d   = up_q ? ptr_q - gsize_a : ptr_q + gsize_a;
        end else if (!pend_q) begin
          state_d = S_COMMIT;
        end
      end

      S_COMMIT: begin
        len_d = newlen_q;
        if (req_q.op == OP_REPLACE) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = req_q.from_pos[ADDR_W-1:0];
          mem_o.wdata = req_q.char_value;
          gap_d       = req_q.from_pos + LEN_W'(1);
        end else begin
          gap_d = req_q.from_pos;
        end
        state_d = S_DONE;
      end

      S_RD_ISSUE: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_q;
        state_d     = S_RD_WAIT;
      end

      S_RD_WAIT: begin
        char_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      S_HASH: begin
        if (hash_issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = (cnt_q < gap_q) ? cnt_q[ADDR_W-1:0]
                                        : cnt_q[ADDR_W-1:0] + gsize_a;
          pend_d      = 1'b1;
          cnt_d       = cnt_q + LEN_W'(1);
        end
        if (pend_q) begin
          hash_d = {hash_q[HASH_W-2:0], 1'b0} ^ {{(HASH_W-CHAR_W){1'b0}}, mem_rdata_i};
        end
        if (!hash_issue && !pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.char_out    = char_q;
  assign res_o.text_length = len_q;
  assign res_o.hash_value  = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gap_q    <= '0;
      len_q    <= '0;
      status_q <= STAT_OK;
      pend_q   <= 1'b0;
      up_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      gap_q    <= gap_d;
      len_q    <= len_d;
      status_q <= status_d;
      pend_q   <= pend_d;
      up_q     <= up_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    char_q    <= char_d;
    hash_q    <= hash_d;
    ptr_q     <= ptr_d;
    wr_addr_q <= wr_addr_d;
    newlen_q  <= newlen_d;
  end

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we && mem_o.re) |-> (mem_o.waddr != mem_o.raddr))
    else $error("text RAM read and write hit the same entry");

  a_len_in_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("text length exceeds capacity");

  a_gap_within_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q <= len_q)
    else $error("gap start lies past the text end");

  a_pend_only_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_MOVE || state_q == S_HASH))
    else $error("read in flight outside a gap move or hash walk");

  a_state_frozen_outside_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COMMIT) |=> $stable(len_q))
    else $error("text length changed outside commit");
`endif

endmodule

FILE: tb/gbte_checker.sv
// Scoreboard for the gap buffer text editor: mirrors the text and checks every result.
module gbte_checker
  import gbte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [OP_W-1:0]        s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [STAT_W-1:0]      m_tuser_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Logical text, gap removed: index i is the i-th character of the document.
  logic [CHAR_W-1:0] text_mirror[$];
  res_t              awaited_results[$];
  int unsigned       errs;

  // Run one operation against the mirrored text and return the response it must produce.
  function automatic res_t run_edit_op(req_t rq);
    res_t              rs;
    int unsigned       from_i;
    int unsigned       to_i;
    int unsigned       len;
    int unsigned       idx;
    logic [HASH_W-1:0] h;
    rs        = '0;
    rs.status = STAT_OK;
    from_i    = rq.from_pos;
    to_i      = rq.to_pos;
    len       = text_mirror.size();
    h         = '0;
    case (rq.op)
      OP_REPLACE: begin
        if (from_i > to_i || to_i > len) begin
          rs.status = STAT_RANGE;
        end else if (len - (to_i - from_i) + 1 > CAPACITY) begin
          rs.status = STAT_FULL;
        end else begin
          repeat (to_i - from_i) text_mirror.delete(from_i);
          text_mirror.insert(from_i, rq.char_value);
        end
      end
      OP_CUT: begin
        if (from_i > to_i || to_i > len) begin
          rs.status = STAT_RANGE;
        end else begin
          repeat (to_i - from_i) text_mirror.delete(from_i);
        end
      end
      OP_READ: begin
        if (len == 0) begin
          rs.status = STAT_RANGE;
        end else begin
          idx         = (from_i > len - 1) ? len - 1 : from_i;
          rs.char_out = text_mirror[idx];
        end
      end
      default: begin
        foreach (text_mirror[i]) h = (h << 1) ^ HASH_W'(text_mirror[i]);
        rs.hash_value = h;
      end
    endcase
    rs.text_length = LEN_W'(text_mirror.size());
    return rs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t rq;
    res_t got;
    res_t want;
    if (!rst_ni) begin
      text_mirror.delete();
      awaited_results.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        rq.op         = op_e'(s_tuser_i);
        rq.from_pos   = s_tdata_i[POS_W-1:0];
        rq.to_pos     = s_tdata_i[2*POS_W-1:POS_W];
        rq.char_value = s_tdata_i[2*POS_W+CHAR_W-1:2*POS_W];
        awaited_results.push_back(run_edit_op(rq));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status      = status_e'(m_tuser_i);
        got.char_out    = m_tdata_i[CHAR_W-1:0];
        got.text_length = m_tdata_i[CHAR_W+LEN_W-1:CHAR_W];
        got.hash_value  = m_tdata_i[CHAR_W+LEN_W+HASH_W-1:CHAR_W+LEN_W];
        if (awaited_results.size() == 0) begin
          errs++;
          $error("result transaction with no operation outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            errs++;
            $error("status: expected %0d, actual %0d", want.status, got.status);
          end
          if (got.char_out !== want.char_out) begin
            errs++;
            $error("char_out: expected %0h, actual %0h", want.char_out, got.char_out);
          end
          if (got.text_length !== want.text_length) begin
            errs++;
            $error("text_length: expected %0d, actual %0d", want.text_length,
                   got.text_length);
          end
          if (got.hash_value !== want.hash_value) begin
            errs++;
            $error("hash_value: expected %0h, actual %0h", want.hash_value,
                   got.hash_value);
          end
        end
      end
      fail_count_o <= errs;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Stimulus and verdict for the gap buffer text editor testbench.
module tb_top;
  import gbte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to hold after the last result so that a stray extra transaction is caught.
  localparam int unsigned DRAIN_CYCLES  = 1000;
  // Random transactions per idling phase.
  localparam int unsigned RANDOM_PER_PH = 340;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic [OP_W-1:0]        s_user;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [STAT_W-1:0]      m_user;
  int unsigned            fail_count;
  int unsigned            pending;

  // Idle percentages of each side, changed between phases by the stimulus process.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Stimulus-side view of the text length and gap position, used only to shape
  // ranges so that most edits are legal and reach deep into the text.
  int unsigned text_len;
  int unsigned gap_hint;

  gap_buffer_text_editor uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  gbte_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .s_tuser_i   (s_user),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .m_tuser_i   (m_user),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: stall at random, one decision per clock edge.
  initial begin
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one operation, hold it until the transaction completes, then update the
  // stimulus-side length and gap position. Valid stays high on return so that a
  // back-to-back operation never drops and re-raises it in the same step.
  task automatic send_op(input op_e op, input int unsigned from_p,
                         input int unsigned to_p, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= IN_TDATA_W'({ch, to_p[POS_W-1:0], from_p[POS_W-1:0]});
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    if (op == OP_REPLACE && from_p <= to_p && to_p <= text_len &&
        text_len - (to_p - from_p) + 1 <= CAPACITY) begin
      text_len = text_len - (to_p - from_p) + 1;
      gap_hint = from_p + 1;
    end else if (op == OP_CUT && from_p <= to_p && to_p <= text_len) begin
      text_len = text_len - (to_p - from_p);
      gap_hint = from_p;
    end
  endtask

  // One random operation: mostly legal edits sized to keep the text a few hundred
  // characters long, plus reads, hashes and a share of raw noise that mostly hits
  // the range checks and the high bits of every field.
  task automatic send_random_op();
    int unsigned pick;
    int unsigned from_p;
    int unsigned to_p;
    int unsigned room;
    int unsigned span_max;
    pick   = $urandom_range(0, 99);
    from_p = $urandom_range(0, text_len);
    room   = text_len - from_p;
    if (pick < 8) begin
      send_op(op_e'($urandom_range(0, 3)), $urandom_range(0, 8191),
              $urandom_range(0, 8191), CHAR_W'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      // Grow while short, replace short runs once long.
      if (text_len < 200) begin
        span_max = ($urandom_range(0, 3) == 0) ? 2 : 0;
      end else begin
        span_max = 4;
      end
      to_p = from_p + $urandom_range(0, (room < span_max) ? room : span_max);
      send_op(OP_REPLACE, from_p, to_p, CHAR_W'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      if ($urandom_range(0, 2) == 0) begin
        // Straddle the gap so that the cut only widens it.
        from_p = gap_hint - ((gap_hint < 3) ? gap_hint : $urandom_range(0, 3));
        to_p   = gap_hint + $urandom_range(0, 3);
        if (to_p > text_len) to_p = text_len;
      end else begin
        span_max = (text_len > 150) ? 60 : 6;
        to_p     = from_p + $urandom_range(0, (room < span_max) ? room : span_max);
      end
      send_op(OP_CUT, from_p, to_p, CHAR_W'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      send_op(OP_READ, $urandom_range(0, text_len + 2), $urandom_range(0, 8191),
              CHAR_W'($urandom_range(0, 255)));
    end else begin
      send_op(OP_HASH, $urandom_range(0, 8191), $urandom_range(0, 8191),
              CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    s_valid       <= 1'b0;
    s_data        <= '0;
    s_user        <= OP_READ;
    rst_ni        <= 1'b0;
    send_idle_pct  = 19;
    recv_idle_pct  = 53;
    text_len       = 0;
    gap_hint       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty text: read and bad ranges are errors, hash is zero, empty cut is legal.
    send_op(OP_READ, 0, 0, 8'h00);
    send_op(OP_HASH, 0, 0, 8'h00);
    send_op(OP_CUT, 0, 0, 8'h00);
    send_op(OP_REPLACE, 0, 1, 8'h11);
    send_op(OP_REPLACE, 1, 0, 8'h22);
    // Build a short text, then insert at the front to pull the gap back.
    send_op(OP_REPLACE, 0, 0, 8'h00);
    send_op(OP_REPLACE, 1, 1, 8'hFF);
    send_op(OP_REPLACE, 2, 2, 8'h55);
    send_op(OP_REPLACE, 3, 3, 8'hAA);
    send_op(OP_REPLACE, 0, 0, 8'h80);
    // Reads: in range, and indexes far past the end that must clamp.
    send_op(OP_READ, 0, 0, 8'h00);
    send_op(OP_READ, 8191, 8191, 8'hFF);
    send_op(OP_READ, 4096, 0, 8'h00);
    // Shrinking replace, a cut around the gap, a cut away from it.
    send_op(OP_REPLACE, 2, 4, 8'h7F);
    send_op(OP_CUT, 1, 3, 8'h00);
    send_op(OP_REPLACE, 2, 2, 8'h01);
    send_op(OP_CUT, 0, 1, 8'h00);
    send_op(OP_HASH, 0, 0, 8'h00);
    // Bad ranges, the first two with the top bits set, then a read inside the text.
    send_op(OP_CUT, 8191, 8191, 8'h00);
    send_op(OP_CUT, 0, 8191, 8'h00);
    send_op(OP_REPLACE, 3, 5, 8'h33);
    send_op(OP_READ, 1, 0, 8'h00);

    // Positions at and past the capacity, mixed with front edits and clamped reads.
    send_op(OP_REPLACE, CAPACITY, CAPACITY, 8'h44);
    send_op(OP_REPLACE, 0, 0, 8'h44);
    send_op(OP_REPLACE, 0, 1, 8'hC3);
    send_op(OP_READ, CAPACITY - 1, 0, 8'h00);
    send_op(OP_READ, 8191, 0, 8'h00);
    send_op(OP_READ, 0, 0, 8'h00);
    send_op(OP_HASH, 0, 0, 8'h00);
    send_op(OP_CUT, CAPACITY - 1, CAPACITY, 8'h00);
    send_op(OP_REPLACE, CAPACITY - 1, CAPACITY - 1, 8'h5A);
    send_op(OP_CUT, 8191, CAPACITY, 8'h00);
    // Cut whose end lies far past the text.
    send_op(OP_CUT, 12, CAPACITY, 8'h00);

    // Random phases: sender idles lightly first, then heavily, then neither side idles.
    repeat (RANDOM_PER_PH) send_random_op();
    send_idle_pct = 53;
    recv_idle_pct = 19;
    repeat (RANDOM_PER_PH) send_random_op();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PH) send_random_op();

    // Release the input, let the last push reach the checker, then drain.
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gbte_pkg.sv
rtl/core/gbte_ram.sv
rtl/core/gbte_seq.sv
rtl/core/gap_buffer_text_editor.sv
tb/gbte_checker.sv
tb/tb_top.sv
